// ===== rtl/core/rsi_pkg.sv =====
// shared types and constants for the ray / sphere intersection pipeline
// no dependencies
package rsi_pkg;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = 6;
  localparam int DATA_W   = 64;
  localparam int ROOT_W   = 64;
  localparam int DISC_W   = 2 * ROOT_W;
  localparam int MAG_W    = 65;
  localparam int QUO_W    = 33;

  typedef enum logic [2:0] {
    REG_ROW0_LO,
    REG_ROW0_HI,
    REG_ROW1_LO,
    REG_ROW1_HI,
    REG_ROW2_LO,
    REG_ROW2_HI,
    REG_CENTER_XY,
    REG_CENTER_Z
  } reg_idx_t;

  // carried alongside the square root
  typedef struct packed {
    logic [63:0] a;
    logic        hneg;
    logic [63:0] hmag;
    logic        hit;
    logic        degen;
    logic        sat;
  } sq_side_t;

  // carried alongside the root division
  typedef struct packed {
    logic hit;
    logic degen;
    logic sat;
  } div_side_t;

  function automatic logic signed [63:0] smul32(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    return 64'(x) * 64'(y);
  endfunction

endpackage

// ===== rtl/core/ray_sphere_intersect.sv =====
// ray versus sphere intersection top level: transform, quadratic, sqrt, roots
// depends on rsi_pkg, rsi_isqrt, rsi_rdiv
// throughput: one request per cycle; the whole pipeline holds while a result waits
// most of the pipeline depth is in the 64-stage square root and 34-stage divider chains
// reset: synchronous, clears all valid bits and loads the identity transform
module ray_sphere_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic signed [31:0]          origin_z,
  input  logic signed [31:0]          dir_x,
  input  logic signed [31:0]          dir_y,
  input  logic signed [31:0]          dir_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic signed [31:0]          t_near,
  output logic signed [31:0]          t_far,
  output logic                        degenerate,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsi_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsi_pkg::DATA_W-1:0]  pwdata,
  output logic [rsi_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam logic [63:0] ONE    = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_SQ = 64'(1) << (2 * FRAC_BITS);
  localparam int          QW1    = rsi_pkg::QUO_W + 1;

  // clamp a wide signed value to 32 bits, msb of the result flags the clamp
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // floor the signed quotient and clamp it, msb flags the clamp
  function automatic logic [32:0] fix_root(input logic ovf_in, input logic neg_in,
                                           input logic inexact_in,
                                           input logic [rsi_pkg::QUO_W-1:0] q);
    logic [QW1-1:0] qq;
    logic [QW1-1:0] qn;
    logic [32:0]    r;
    qq = {1'b0, q} + QW1'(neg_in && inexact_in);
    qn = -qq;
    if (!neg_in) begin
      if (ovf_in || qq > QW1'(32'h7FFF_FFFF)) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, qq[31:0]};
      end
    end else begin
      if (ovf_in || qq > QW1'(32'h8000_0000)) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, qn[31:0]};
      end
    end
    return r;
  endfunction

  // global advance: everything moves unless a finished result is held back
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]       cfg_reg [0:rsi_pkg::NUM_REGS-1];
  logic              cfg_wr;
  rsi_pkg::reg_idx_t wr_idx;

  assign cfg_wr = psel && penable && pwrite;
  assign wr_idx = rsi_pkg::reg_idx_t'(paddr[rsi_pkg::ADDR_W-1:3]);
  assign pready = 1'b1;
  assign prdata = cfg_reg[paddr[rsi_pkg::ADDR_W-1:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg[rsi_pkg::REG_ROW0_LO]   <= ONE;
      cfg_reg[rsi_pkg::REG_ROW0_HI]   <= 64'd0;
      cfg_reg[rsi_pkg::REG_ROW1_LO]   <= ONE << 32;
      cfg_reg[rsi_pkg::REG_ROW1_HI]   <= 64'd0;
      cfg_reg[rsi_pkg::REG_ROW2_LO]   <= 64'd0;
      cfg_reg[rsi_pkg::REG_ROW2_HI]   <= ONE;
      cfg_reg[rsi_pkg::REG_CENTER_XY] <= 64'd0;
      cfg_reg[rsi_pkg::REG_CENTER_Z]  <= 64'd0;
    end else if (cfg_wr) begin
      case (wr_idx)
        // center z is a single 32-bit word
        rsi_pkg::REG_CENTER_Z: cfg_reg[wr_idx] <= {32'd0, pwdata[31:0]};
        default:               cfg_reg[wr_idx] <= pwdata;
      endcase
    end
  end

  // matrix words m[row][col], col 3 is the translation
  logic signed [31:0] m   [0:2][0:3];
  logic signed [31:0] ctr [0:2];
  logic signed [31:0] org [0:2];
  logic signed [31:0] dir [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i][0] = cfg_reg[3'(2 * i)][31:0];
      m[i][1] = cfg_reg[3'(2 * i)][63:32];
      m[i][2] = cfg_reg[3'(2 * i + 1)][31:0];
      m[i][3] = cfg_reg[3'(2 * i + 1)][63:32];
    end
  end

  assign ctr[0] = cfg_reg[rsi_pkg::REG_CENTER_XY][31:0];
  assign ctr[1] = cfg_reg[rsi_pkg::REG_CENTER_XY][63:32];
  assign ctr[2] = cfg_reg[rsi_pkg::REG_CENTER_Z][31:0];
  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  // ---------------------------------------------------------------------------
  // stage 1: matrix products, origin and direction
  // ---------------------------------------------------------------------------
  logic               v1;
  logic signed [63:0] prod_o [0:2][0:2];
  logic signed [63:0] prod_d [0:2][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_o[i][j] <= rsi_pkg::smul32(m[i][j], org[j]);
          prod_d[i][j] <= rsi_pkg::smul32(m[i][j], dir[j]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: row sums plus translation, floor to Q(F), clamp
  // ---------------------------------------------------------------------------
  logic               v2;
  logic               sat2;
  logic signed [31:0] o2 [0:2];
  logic signed [31:0] d2 [0:2];
  logic signed [65:0] sum_o [0:2];
  logic signed [65:0] sum_d [0:2];
  logic [32:0]        cl_o [0:2];
  logic [32:0]        cl_d [0:2];
  logic               sat_fold;

  always_comb begin
    sat_fold = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_o[i] = 66'(prod_o[i][0]) + 66'(prod_o[i][1]) + 66'(prod_o[i][2])
               + (66'(m[i][3]) <<< FRAC_BITS);
      sum_d[i] = 66'(prod_d[i][0]) + 66'(prod_d[i][1]) + 66'(prod_d[i][2]);
      cl_o[i]  = sat32(sum_o[i] >>> FRAC_BITS);
      cl_d[i]  = sat32(sum_d[i] >>> FRAC_BITS);
      sat_fold = sat_fold | cl_o[i][32] | cl_d[i][32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat2 <= sat_fold;
      for (int i = 0; i < 3; i++) begin
        o2[i] <= cl_o[i][31:0];
        d2[i] <= cl_d[i][31:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: offset from the sphere center
  // ---------------------------------------------------------------------------
  logic               v3;
  logic               sat3;
  logic signed [31:0] s3 [0:2];
  logic signed [31:0] d3 [0:2];
  logic [32:0]        cl_s [0:2];
  logic               sat_off;

  always_comb begin
    sat_off = sat2;
    for (int i = 0; i < 3; i++) begin
      cl_s[i] = sat32(66'(o2[i]) - 66'(ctr[i]));
      sat_off = sat_off | cl_s[i][32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat3 <= sat_off;
      for (int i = 0; i < 3; i++) begin
        s3[i] <= cl_s[i][31:0];
        d3[i] <= d2[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: dot product terms
  // ---------------------------------------------------------------------------
  logic               v4;
  logic               sat4;
  logic signed [63:0] dd4 [0:2];
  logic signed [63:0] ss4 [0:2];
  logic signed [63:0] ds4 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat4 <= sat3;
      for (int i = 0; i < 3; i++) begin
        dd4[i] <= rsi_pkg::smul32(d3[i], d3[i]);
        ss4[i] <= rsi_pkg::smul32(s3[i], s3[i]);
        ds4[i] <= rsi_pkg::smul32(d3[i], s3[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: a = D.D, S.S, half-b h = D.S
  // ---------------------------------------------------------------------------
  logic               v5;
  logic               sat5;
  logic [63:0]        a5;
  logic [63:0]        ss5;
  logic signed [65:0] h5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat5 <= sat4;
      a5   <= $unsigned(dd4[0]) + $unsigned(dd4[1]) + $unsigned(dd4[2]);
      ss5  <= $unsigned(ss4[0]) + $unsigned(ss4[1]) + $unsigned(ss4[2]);
      h5   <= 66'(ds4[0]) + 66'(ds4[1]) + 66'(ds4[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: magnitudes of h and c = S.S - 1
  // ---------------------------------------------------------------------------
  logic               v6;
  logic               sat6;
  logic               degen6;
  logic               hneg6;
  logic               cneg6;
  logic [63:0]        a6;
  logic [63:0]        hmag6;
  logic [63:0]        cmag6;
  logic signed [65:0] habs;
  logic               c_below;

  assign habs    = h5[65] ? -h5 : h5;
  assign c_below = ss5 < ONE_SQ;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (advance) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat6   <= sat5;
      degen6 <= a5 == 64'd0;
      hneg6  <= h5[65];
      hmag6  <= habs[63:0];
      cneg6  <= c_below;
      cmag6  <= c_below ? ONE_SQ - ss5 : ss5 - ONE_SQ;
      a6     <= a5;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: 32x32 partial products of h*h and a*c
  // ---------------------------------------------------------------------------
  logic        v7;
  logic        sat7;
  logic        degen7;
  logic        hneg7;
  logic        cneg7;
  logic [63:0] a7;
  logic [63:0] hmag7;
  logic [63:0] hp00, hp01, hp11;
  logic [63:0] ap00, ap01, ap10, ap11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (advance) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat7   <= sat6;
      degen7 <= degen6;
      hneg7  <= hneg6;
      cneg7  <= cneg6;
      a7     <= a6;
      hmag7  <= hmag6;
      hp00   <= 64'(hmag6[31:0]) * 64'(hmag6[31:0]);
      hp01   <= 64'(hmag6[31:0]) * 64'(hmag6[63:32]);
      hp11   <= 64'(hmag6[63:32]) * 64'(hmag6[63:32]);
      ap00   <= 64'(a6[31:0]) * 64'(cmag6[31:0]);
      ap01   <= 64'(a6[31:0]) * 64'(cmag6[63:32]);
      ap10   <= 64'(a6[63:32]) * 64'(cmag6[31:0]);
      ap11   <= 64'(a6[63:32]) * 64'(cmag6[63:32]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: assemble h*h and a*c
  // ---------------------------------------------------------------------------
  logic         v8;
  logic         sat8;
  logic         degen8;
  logic         hneg8;
  logic         cneg8;
  logic [63:0]  a8;
  logic [63:0]  hmag8;
  logic [127:0] hh8;
  logic [127:0] ac8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (advance) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sat8   <= sat7;
      degen8 <= degen7;
      hneg8  <= hneg7;
      cneg8  <= cneg7;
      a8     <= a7;
      hmag8  <= hmag7;
      // cross term appears twice, hence the 33-bit shift
      hh8    <= {hp11, 64'd0} + {31'd0, hp01, 33'd0} + {64'd0, hp00};
      ac8    <= {ap11, 64'd0} + {32'd0, ap01, 32'd0} + {32'd0, ap10, 32'd0}
              + {64'd0, ap00};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: discriminant h*h - a*c and hit decision
  // ---------------------------------------------------------------------------
  logic              v9;
  logic [127:0]      disc9;
  rsi_pkg::sq_side_t side9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (advance) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      disc9       <= cneg8 ? hh8 + ac8 : hh8 - ac8;
      side9.a     <= a8;
      side9.hneg  <= hneg8;
      side9.hmag  <= hmag8;
      side9.hit   <= !degen8 && (cneg8 || hh8 >= ac8);
      side9.degen <= degen8;
      side9.sat   <= sat8;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 10..73: square root of the discriminant
  // ---------------------------------------------------------------------------
  logic              sq_valid;
  logic [63:0]       sq_root;
  rsi_pkg::sq_side_t sq_side;

  rsi_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v9),
    .x         (disc9),
    .side_in   (side9),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // ---------------------------------------------------------------------------
  // stage 74: numerators -h - sqrt and -h + sqrt in sign / magnitude
  // ---------------------------------------------------------------------------
  logic                      vn;
  logic [63:0]               an;
  logic                      near_neg;
  logic                      far_neg;
  logic [rsi_pkg::MAG_W-1:0] near_mag;
  logic [rsi_pkg::MAG_W-1:0] far_mag;
  rsi_pkg::div_side_t        side_n;
  logic [66:0]               neg_h;
  logic [66:0]               num_near;
  logic [66:0]               num_far;
  logic [66:0]               abs_near;
  logic [66:0]               abs_far;

  assign neg_h    = sq_side.hneg ? {3'd0, sq_side.hmag} : -{3'd0, sq_side.hmag};
  assign num_near = neg_h - {3'd0, sq_root};
  assign num_far  = neg_h + {3'd0, sq_root};
  assign abs_near = num_near[66] ? -num_near : num_near;
  assign abs_far  = num_far[66] ? -num_far : num_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (advance) begin
      vn <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      an           <= sq_side.a;
      near_neg     <= num_near[66];
      far_neg      <= num_far[66];
      near_mag     <= abs_near[rsi_pkg::MAG_W-1:0];
      far_mag      <= abs_far[rsi_pkg::MAG_W-1:0];
      side_n.hit   <= sq_side.hit;
      side_n.degen <= sq_side.degen;
      side_n.sat   <= sq_side.sat;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 75..108: two root dividers in lockstep
  // ---------------------------------------------------------------------------
  logic                      dv_valid;
  logic [rsi_pkg::QUO_W-1:0] q_near;
  logic [rsi_pkg::QUO_W-1:0] q_far;
  logic                      inx_near, inx_far;
  logic                      ovf_near, ovf_far;
  logic                      sgn_near, sgn_far;
  rsi_pkg::div_side_t        dside;

  rsi_rdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_near (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (vn),
    .a         (an),
    .neg_in    (near_neg),
    .mag       (near_mag),
    .side_in   (side_n),
    .out_valid (dv_valid),
    .quo       (q_near),
    .inexact   (inx_near),
    .ovf       (ovf_near),
    .neg_out   (sgn_near),
    .side_out  (dside)
  );

  rsi_rdiv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div_far (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (vn),
    .a         (an),
    .neg_in    (far_neg),
    .mag       (far_mag),
    .side_in   (side_n),
    .out_valid (),
    .quo       (q_far),
    .inexact   (inx_far),
    .ovf       (ovf_far),
    .neg_out   (sgn_far),
    .side_out  ()
  );

  // ---------------------------------------------------------------------------
  // stage 109: floor, clamp and output register
  // ---------------------------------------------------------------------------
  logic [32:0] rt_near;
  logic [32:0] rt_far;

  assign rt_near = fix_root(ovf_near, sgn_near, inx_near, q_near);
  assign rt_far  = fix_root(ovf_far, sgn_far, inx_far, q_far);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit        <= dside.hit;
      t_near     <= dside.hit ? rt_near[31:0] : 32'sd0;
      t_far      <= dside.hit ? rt_far[31:0] : 32'sd0;
      degenerate <= dside.degen;
      // root clamps only count for a ray that hits
      saturated  <= dside.sat | (dside.hit & (rt_near[32] | rt_far[32]));
    end
  end

`ifndef SYNTH
  a_hit_not_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && degenerate))
    else $error("hit reported for a degenerate direction");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (t_near == 32'sd0 && t_far == 32'sd0))
    else $error("nonzero roots on a miss");

  a_root_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (t_near <= t_far))
    else $error("near root above far root");
`endif

endmodule

// ===== rtl/core/rsi_isqrt.sv =====
// pipelined integer square root of a 128-bit value, one result bit per stage
// depends on rsi_pkg
module rsi_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [127:0]            x,
  input  rsi_pkg::sq_side_t       side_in,
  output logic                    out_valid,
  output logic [63:0]             root,
  output rsi_pkg::sq_side_t       side_out
);

  localparam int NS = rsi_pkg::ROOT_W;

  logic              v_q    [1:NS];
  logic [64:0]       rem_q  [1:NS];
  logic [63:0]       root_q [1:NS];
  logic [127:0]      x_q    [1:NS];
  rsi_pkg::sq_side_t side_q [1:NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              v_c;
    logic [64:0]       rem_c;
    logic [63:0]       root_c;
    logic [127:0]      x_c;
    rsi_pkg::sq_side_t side_c;
    logic [66:0]       rem_sh;
    logic [66:0]       trial;
    logic [66:0]       diff;
    logic              ge;

    if (k == 0) begin : g_head
      assign v_c    = in_valid;
      assign rem_c  = '0;
      assign root_c = '0;
      assign x_c    = x;
      assign side_c = side_in;
    end else begin : g_body
      assign v_c    = v_q[k];
      assign rem_c  = rem_q[k];
      assign root_c = root_q[k];
      assign x_c    = x_q[k];
      assign side_c = side_q[k];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_c, x_c[127:126]};
    assign trial  = {1'b0, root_c, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? diff[64:0] : rem_sh[64:0];
        root_q[k+1] <= {root_c[62:0], ge};
        x_q[k+1]    <= {x_c[125:0], 2'b00};
        side_q[k+1] <= side_c;
      end
    end
  end

  assign out_valid = v_q[NS];
  assign root      = root_q[NS];
  assign side_out  = side_q[NS];

endmodule

// ===== rtl/core/rsi_rdiv.sv =====
// pipelined restoring divider for one root: (mag << FRAC_BITS) / a
// depends on rsi_pkg
module rsi_rdiv #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [63:0]                 a,
  input  logic                        neg_in,
  input  logic [rsi_pkg::MAG_W-1:0]   mag,
  input  rsi_pkg::div_side_t          side_in,
  output logic                        out_valid,
  output logic [rsi_pkg::QUO_W-1:0]   quo,
  output logic                        inexact,
  output logic                        ovf,
  output logic                        neg_out,
  output rsi_pkg::div_side_t          side_out
);

  localparam int QB = rsi_pkg::QUO_W;
  localparam int NW = rsi_pkg::MAG_W + FRAC_BITS;

  logic [NW-1:0] num;

  logic               v_q    [0:QB];
  logic [63:0]        rem_q  [0:QB];
  logic [QB-1:0]      nlo_q  [0:QB];
  logic [QB-1:0]      quo_q  [0:QB];
  logic [63:0]        a_q    [0:QB];
  logic               neg_q  [0:QB];
  logic               ovf_q  [0:QB];
  rsi_pkg::div_side_t side_q [0:QB];

  assign num = {mag, {FRAC_BITS{1'b0}}};

  // quotient too wide for the kept bits when the upper part already reaches a
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_q[0]  <= 64'(num[NW-1:QB]) >= a;
      rem_q[0]  <= 64'(num[NW-1:QB]);
      nlo_q[0]  <= num[QB-1:0];
      quo_q[0]  <= '0;
      a_q[0]    <= a;
      neg_q[0]  <= neg_in;
      side_q[0] <= side_in;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [64:0] rem_sh;
    logic [64:0] diff;
    logic        ge;

    assign rem_sh = {rem_q[k], nlo_q[k][QB-1]};
    assign ge     = rem_sh >= {1'b0, a_q[k]};
    assign diff   = rem_sh - {1'b0, a_q[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1]  <= ge ? diff[63:0] : rem_sh[63:0];
        quo_q[k+1]  <= {quo_q[k][QB-2:0], ge};
        nlo_q[k+1]  <= {nlo_q[k][QB-2:0], 1'b0};
        a_q[k+1]    <= a_q[k];
        neg_q[k+1]  <= neg_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = v_q[QB];
  assign quo       = quo_q[QB];
  assign inexact   = rem_q[QB] != 64'd0;
  assign ovf       = ovf_q[QB];
  assign neg_out   = neg_q[QB];
  assign side_out  = side_q[QB];

endmodule

// ===== tb/rsi_checker.sv =====
// watches the ray and result channels, predicts each result and compares it
// depends on rsi_pkg for the register indexes
`timescale 1ns / 100ps

module rsi_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  input  logic signed [31:0] t_near,
  input  logic signed [31:0] t_far,
  input  logic               degenerate,
  input  logic               saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
    logic               degen;
    logic               sat;
  } isect_t;

  logic [63:0] regs [rsi_pkg::NUM_REGS];
  isect_t      expected_q [$];

  assign pending = expected_q.size();

  function automatic logic signed [31:0] word_of(logic [63:0] r, bit upper);
    return upper ? r[63:32] : r[31:0];
  endfunction

  // floor of a Q(2F) value to Q(F), clamped to 32 bits
  function automatic logic signed [31:0] fold(logic signed [127:0] v, ref bit sat);
    logic signed [127:0] f;
    f = v >>> FRAC_BITS;
    if (f > 128'sh7fffffff) begin sat = 1; return 32'sh7fffffff; end
    if (f < -128'sh80000000) begin sat = 1; return 32'sh80000000; end
    return f[31:0];
  endfunction

  function automatic logic [127:0] sqrt_floor(logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  cand;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= x) r = cand;
    end
    return {64'd0, r};
  endfunction

  // (num << FRAC_BITS) / a, floored, clamped to 32 bits
  function automatic logic signed [31:0] root_of(logic signed [127:0] num,
                                                 logic [63:0] a, ref bit sat);
    logic signed [127:0] n, q, dv;
    n  = num <<< FRAC_BITS;
    dv = $signed({64'd0, a});
    q  = n / dv;
    if ((n % dv) != 0 && n < 0) q = q - 1;
    if (q > 128'sh7fffffff) begin sat = 1; return 32'sh7fffffff; end
    if (q < -128'sh80000000) begin sat = 1; return 32'sh80000000; end
    return q[31:0];
  endfunction

  function automatic isect_t predict_isect(logic signed [31:0] o [3],
                                           logic signed [31:0] d [3]);
    isect_t r;
    bit sat;
    logic signed [127:0] oa, da, m, a, h, cc, disc, sq, s [3], dd [3];
    logic signed [63:0] sd;
    sat = 0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      oa = 0;
      da = 0;
      for (int j = 0; j < 3; j++) begin
        m  = word_of(regs[i*2 + j/2], j % 2);
        oa = oa + m * o[j];
        da = da + m * d[j];
      end
      oa = oa + (128'(word_of(regs[i*2 + 1], 1)) <<< FRAC_BITS);
      dd[i] = fold(da, sat);
      sd = 64'(fold(oa, sat)) - 64'(word_of(i == 2 ? regs[rsi_pkg::REG_CENTER_Z] :
             regs[rsi_pkg::REG_CENTER_XY], i == 1));
      if (sd > 64'sh7fffffff) begin sat = 1; sd = 64'sh7fffffff; end
      if (sd < -64'sh80000000) begin sat = 1; sd = -64'sh80000000; end
      s[i] = sd;
    end
    a  = dd[0]*dd[0] + dd[1]*dd[1] + dd[2]*dd[2];
    h  = dd[0]*s[0] + dd[1]*s[1] + dd[2]*s[2];
    cc = s[0]*s[0] + s[1]*s[1] + s[2]*s[2] - (128'sd1 <<< (2*FRAC_BITS));
    r.degen = (a == 0);
    if (!r.degen) begin
      disc = h*h - a*cc;
      if (disc >= 0) begin
        r.hit = 1;
        sq = sqrt_floor(disc);
        r.t_near = root_of(-h - sq, a[63:0], sat);
        r.t_far  = root_of(-h + sq, a[63:0], sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] o [3], d [3];
    isect_t e;
    if (rst) begin
      regs[rsi_pkg::REG_ROW0_LO]   <= 64'd1 << FRAC_BITS;
      regs[rsi_pkg::REG_ROW0_HI]   <= '0;
      regs[rsi_pkg::REG_ROW1_LO]   <= 64'd1 << (FRAC_BITS + 32);
      regs[rsi_pkg::REG_ROW1_HI]   <= '0;
      regs[rsi_pkg::REG_ROW2_LO]   <= '0;
      regs[rsi_pkg::REG_ROW2_HI]   <= 64'd1 << FRAC_BITS;
      regs[rsi_pkg::REG_CENTER_XY] <= '0;
      regs[rsi_pkg::REG_CENTER_Z]  <= '0;
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[5:3] < rsi_pkg::NUM_REGS)
        regs[paddr[5:3]] <= (paddr[5:3] == rsi_pkg::REG_CENTER_Z) ?
                            {32'd0, pwdata[31:0]} : pwdata;
      if (in_valid && in_ready) begin
        o = '{origin_x, origin_y, origin_z};
        d = '{dir_x, dir_y, dir_z};
        expected_q = {expected_q, predict_isect(o, d)};
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != {hit, t_near, t_far, degenerate, saturated}) begin
            if (e.hit != hit) $error("hit exp %0d got %0d", e.hit, hit);
            if (e.t_near != t_near) $error("t_near exp %0d got %0d", e.t_near, t_near);
            if (e.t_far != t_far) $error("t_far exp %0d got %0d", e.t_far, t_far);
            if (e.degen != degenerate)
              $error("degenerate exp %0d got %0d", e.degen, degenerate);
            if (e.sat != saturated)
              $error("saturated exp %0d got %0d", e.sat, saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the ray / sphere intersection block
// depends on rsi_pkg, ray_sphere_intersect and rsi_checker
`timescale 1ns / 100ps

module testbench;

  localparam int ONE       = 1 << 16;
  localparam int LATENCY   = 109;
  localparam int MAX_CYCLES = 1_000_000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic hit, degenerate, saturated;
  logic signed [31:0] t_near, t_far;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [5:0] paddr = 0;
  logic [63:0] pwdata = 0, prdata;
  int errors, pending;
  int cycles = 0;
  bit calm = 0;      // no idling near the end

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  ray_sphere_intersect dut (.*);

  rsi_checker chk (.*);

  // overall cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side stalls in random bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  task automatic write_reg(rsi_pkg::reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // wait until every expected result is back, then for the pipeline to drain
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // send one request, holding it until accepted
  task automatic send_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 0;
      default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  function automatic logic [63:0] mat_pair(bit wild);
    logic [31:0] w [2];
    for (int i = 0; i < 2; i++)
      w[i] = wild ? $urandom() : $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
    return {w[1], w[0]};
  endfunction

  initial begin
    logic signed [31:0] d;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: identity transform, unit sphere at origin
    send_ray(-4 * ONE, 0, 0, ONE, 0, 0);                  // straight hit
    send_ray(0, 0, 0, 0, 0, ONE);                          // origin inside
    send_ray(0, 2 * ONE, 0, ONE, 0, 0);                    // miss
    send_ray(0, ONE, -5 * ONE, 0, 0, ONE);                 // tangent
    send_ray(3 * ONE, 0, 0, 0, 0, 0);                      // zero direction
    send_ray(0, 0, 0, 1, 0, 0);                            // tiny direction, root clamps
    send_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_ray(32'sh80000000, 0, 0, -1, -1, -1);
    send_ray(-1, -1, -1, 32'sh7fffffff, 0, 32'sh80000000);
    send_ray(5 * ONE, 0, 0, -ONE, 0, 0);                   // hit from behind
    stop_sending();
    drain();

    // extreme transform and center
    write_reg(rsi_pkg::REG_ROW0_LO, {32'h7fffffff, 32'h80000000});
    write_reg(rsi_pkg::REG_ROW0_HI, {32'h80000000, 32'h7fffffff});
    write_reg(rsi_pkg::REG_ROW1_LO, {32'h80000000, 32'h7fffffff});
    write_reg(rsi_pkg::REG_ROW1_HI, {32'h7fffffff, 32'h80000000});
    write_reg(rsi_pkg::REG_ROW2_LO, 64'hffffffff_ffffffff);
    write_reg(rsi_pkg::REG_ROW2_HI, 64'h80000000_7fffffff);
    write_reg(rsi_pkg::REG_CENTER_XY, {32'h80000000, 32'h7fffffff});
    write_reg(rsi_pkg::REG_CENTER_Z, 64'hdeadbeef_80000000);
    send_ray(ONE, ONE, ONE, ONE, -ONE, ONE);
    send_ray(0, 0, 0, 1, 1, 1);
    send_ray(-ONE, 2 * ONE, 0, 0, 0, -ONE);
    stop_sending();
    drain();

    // random phases under several settings
    for (int ph = 0; ph < 7; ph++) begin
      bit wild;
      wild = (ph % 3 == 2);
      write_reg(rsi_pkg::REG_ROW0_LO, ph == 0 ? 64'(ONE) : mat_pair(wild));
      write_reg(rsi_pkg::REG_ROW0_HI, ph == 0 ? 64'd0 : mat_pair(wild));
      write_reg(rsi_pkg::REG_ROW1_LO, ph == 0 ? 64'(ONE) << 32 : mat_pair(wild));
      write_reg(rsi_pkg::REG_ROW1_HI, ph == 0 ? 64'd0 : mat_pair(wild));
      write_reg(rsi_pkg::REG_ROW2_LO, ph == 0 ? 64'd0 : mat_pair(wild));
      write_reg(rsi_pkg::REG_ROW2_HI, ph == 0 ? 64'(ONE) : mat_pair(wild));
      write_reg(rsi_pkg::REG_CENTER_XY, mat_pair(wild));
      write_reg(rsi_pkg::REG_CENTER_Z, mat_pair(wild));
      calm = (ph == 6);
      for (int k = 0; k < 250; k++) begin
        d = coord();
        send_ray(coord(), coord(), coord(),
                 $urandom_range(0, 9) == 0 ? 0 : d, coord(), coord());
        if (k == 120 && ph == 3) begin
          // let everything in flight come back before going on
          stop_sending();
          while (pending != 0) @(posedge clk);
        end
      end
      stop_sending();
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
